// ===== hdl/longest_prefix_match_router_assert.svh =====
// assertion macros for the route table checker
`ifndef LONGEST_PREFIX_MATCH_ROUTER_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpm check failed");

// consequent checked in the cycle after the antecedent
`define LPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpm check failed");

`endif

// ===== hdl/lpm_pkg.sv =====
// types and constants shared by the route table modules
`timescale 1ns / 1ps

package lpm_pkg;

  localparam int unsigned AddrW         = 32;
  localparam int unsigned LenW          = 6;
  localparam int unsigned IfaceW        = 4;
  localparam int unsigned TtlW          = 8;
  localparam int unsigned TableDepthDef = 64;
  localparam logic [LenW-1:0] MaxLen    = LenW'(32);

  typedef enum logic [2:0] {
    StAdded   = 3'd0,
    StForward = 3'd1,
    StDropTtl = 3'd2,
    StNoRoute = 3'd3,
    StFull    = 3'd4
  } status_e;

  typedef enum logic {
    FsmIdle,
    FsmSearch
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [AddrW-1:0]  route_prefix_in;
    logic [LenW-1:0]   prefix_len_in;
    logic              hop_valid_in;
    logic [AddrW-1:0]  hop_addr_in;
    logic [IfaceW-1:0] iface_in;
    logic [AddrW-1:0]  dest_addr;
    logic [TtlW-1:0]   ttl_in;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [TtlW-1:0]   ttl_out;
    logic [AddrW-1:0]  next_hop_out;
    logic [IfaceW-1:0] iface_out;
  } result_t;

  // one stored route
  typedef struct packed {
    logic [AddrW-1:0]  prefix;
    logic [LenW-1:0]   len;
    logic              hop_valid;
    logic [AddrW-1:0]  hop;
    logic [IfaceW-1:0] iface;
  } route_t;

  // lookup token walking down the cell row
  typedef struct packed {
    logic [AddrW-1:0]  dst;
    logic [TtlW-1:0]   ttl;
    logic              have_best;
    logic [LenW-1:0]   best_len;
    logic              best_hop_valid;
    logic [AddrW-1:0]  best_hop;
    logic [IfaceW-1:0] best_iface;
    logic              have_def;
    logic              def_hop_valid;
    logic [AddrW-1:0]  def_hop;
    logic [IfaceW-1:0] def_iface;
  } token_t;

endpackage

// ===== hdl/lpm_cell.sv =====
// one route table slot that updates the passing lookup token
`timescale 1ns / 1ps

module lpm_cell import lpm_pkg::*; #(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  route_t          wr_route_i,
  input  logic            tok_vld_i,
  input  token_t          tok_i,
  output logic            tok_vld_o,
  output token_t          tok_o
);

  function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= MaxLen) begin
      m = '1;
    end else begin
      m = {AddrW{1'b1}} << (MaxLen - len);
    end
    return m;
  endfunction

  logic   ent_vld_q;
  route_t ent_q;
  logic   tok_vld_q;
  token_t tok_q, tok_d;
  logic   hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
    end else if (wr_en_i && wr_idx_i == IdxW'(CellIdx)) begin
      ent_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i == IdxW'(CellIdx)) begin
      ent_q <= wr_route_i;
    end
  end

  assign hit = ((ent_q.prefix ^ tok_i.dst) & len_mask(ent_q.len)) == '0;

  always_comb begin
    tok_d = tok_i;
    if (ent_vld_q) begin
      if (ent_q.len == '0) begin
        // later default routes replace earlier ones
        tok_d.have_def      = 1'b1;
        tok_d.def_hop_valid = ent_q.hop_valid;
        tok_d.def_hop       = ent_q.hop;
        tok_d.def_iface     = ent_q.iface;
      end else if (hit && ent_q.len > tok_i.best_len) begin
        // strictly longer only, so the first of equal length stays
        tok_d.have_best      = 1'b1;
        tok_d.best_len       = ent_q.len;
        tok_d.best_hop_valid = ent_q.hop_valid;
        tok_d.best_hop       = ent_q.hop;
        tok_d.best_iface     = ent_q.iface;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

// ===== hdl/longest_prefix_match_router.sv =====
// ipv4 route table with longest prefix match over a row of cells
`timescale 1ns / 1ps

// An item is taken at a clock edge with start high and busy low, and gives exactly
// one result: result_valid_o is high for one cycle with result_o, and the receiver
// has no way to hold it off. Adds, rejected adds and TTL drops answer in the cycle after
// the accept and leave busy low. A route lookup walks a token down the row of
// TABLE_DEPTH cells, one cell per cycle, and its answer is registered after the last
// cell, with busy high until the answer appears; the next item can be taken
// in the cycle the answer is shown.
module longest_prefix_match_router import lpm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  state_e        state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          res_vld_q, res_vld_d;
  result_t       res_q, res_d;
  logic          accept;
  logic          wr_en;
  logic          lookup_go;
  route_t        wr_route;
  logic          tok_vld [TABLE_DEPTH+1];
  token_t        tok     [TABLE_DEPTH+1];
  token_t        tok_end;

  assign busy   = (state_q == FsmSearch);
  assign accept = start && !busy;

  always_comb begin
    wr_route.prefix    = cmd_i.route_prefix_in;
    wr_route.len       = (cmd_i.prefix_len_in > MaxLen) ? MaxLen : cmd_i.prefix_len_in;
    wr_route.hop_valid = cmd_i.hop_valid_in;
    wr_route.hop       = cmd_i.hop_addr_in;
    wr_route.iface     = cmd_i.iface_in;
  end

  assign tok[0]     = '{dst: cmd_i.dest_addr, ttl: cmd_i.ttl_in, default: '0};
  assign tok_vld[0] = lookup_go;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lpm_cell #(
      .IdxW    (IdxW),
      .CellIdx (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en),
      .wr_idx_i   (cnt_q[IdxW-1:0]),
      .wr_route_i (wr_route),
      .tok_vld_i  (tok_vld[i]),
      .tok_i      (tok[i]),
      .tok_vld_o  (tok_vld[i+1]),
      .tok_o      (tok[i+1])
    );
  end

  assign tok_end = tok[TABLE_DEPTH];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    res_vld_d = 1'b0;
    res_d     = '0;
    wr_en     = 1'b0;
    lookup_go = 1'b0;
    unique case (state_q)
      FsmIdle: begin
        if (accept) begin
          if (!cmd_i.mode) begin
            res_vld_d = 1'b1;
            if (cnt_q == CntW'(TABLE_DEPTH)) begin
              res_d.status = StFull;
            end else begin
              wr_en        = 1'b1;
              cnt_d        = cnt_q + 1'b1;
              res_d.status = StAdded;
            end
          end else if (cmd_i.ttl_in <= TtlW'(1)) begin
            res_vld_d    = 1'b1;
            res_d.status = StDropTtl;
          end else begin
            lookup_go = 1'b1;
            state_d   = FsmSearch;
          end
        end
      end
      FsmSearch: begin
        if (tok_vld[TABLE_DEPTH]) begin
          res_vld_d = 1'b1;
          state_d   = FsmIdle;
          if (tok_end.have_best) begin
            res_d.status       = StForward;
            res_d.ttl_out      = tok_end.ttl - 1'b1;
            res_d.next_hop_out = tok_end.best_hop_valid ? tok_end.best_hop : tok_end.dst;
            res_d.iface_out    = tok_end.best_iface;
          end else if (tok_end.have_def) begin
            res_d.status       = StForward;
            res_d.ttl_out      = tok_end.ttl - 1'b1;
            res_d.next_hop_out = tok_end.def_hop_valid ? tok_end.def_hop : tok_end.dst;
            res_d.iface_out    = tok_end.def_iface;
          end else begin
            res_d.status = StNoRoute;
          end
        end
      end
      default: begin
        state_d = FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FsmIdle;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ===== hdl/lpm_checker.sv =====
// port level checks for the route table, bound to the top level
`timescale 1ns / 1ps
`include "longest_prefix_match_router_assert.svh"

module lpm_checker import lpm_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd_i,
  input logic    result_valid_o,
  input result_t result_o
);

  `LPM_ASSERT_SAME(a_status_code, result_valid_o, result_o.status == StAdded || result_o.status == StForward || result_o.status == StDropTtl || result_o.status == StNoRoute || result_o.status == StFull)
  `LPM_ASSERT_SAME(a_idle_fields_zero, result_valid_o && result_o.status != StForward, result_o.ttl_out == '0 && result_o.next_hop_out == '0 && result_o.iface_out == '0)
  `LPM_ASSERT_NEXT(a_add_answers, start && !busy && !cmd_i.mode, result_valid_o && !busy && (result_o.status == StAdded || result_o.status == StFull))
  `LPM_ASSERT_NEXT(a_ttl_drop, start && !busy && cmd_i.mode && cmd_i.ttl_in <= 8'd1, result_valid_o && result_o.status == StDropTtl)
  `LPM_ASSERT_NEXT(a_lookup_busy, start && !busy && cmd_i.mode && cmd_i.ttl_in > 8'd1, busy && !result_valid_o)

endmodule

bind longest_prefix_match_router lpm_checker u_lpm_checker (.*);
